@@ hw/rtl/srs_pkg.sv @@
// Package with the field widths and allele codes shared by the run segmenter.
package srs_pkg;

   localparam int COUNT_BITS = 24;
   localparam int CODE_BITS  = 2;

   typedef logic [CODE_BITS-1:0]  code_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   localparam code_type CODE_MISSING = 2'd0;
   localparam code_type CODE_HOM_A   = 2'd1;
   localparam code_type CODE_HOM_B   = 2'd3;

   localparam count_type COUNT_MAX    = '1;
   localparam count_type MIN_LEN_INIT = 24'd1;

endpackage

@@ hw/rtl/srs_core.sv @@
// Run tracking state and the per-locus update that decides whether a run is emitted.
module srs_core #(
   parameter int POSITION_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  srs_pkg::code_type        hap_code,
   input  srs_pkg::code_type        geno_code,
   input  logic                     region_last,
   input  srs_pkg::count_type       min_length,
   output logic                     emit,
   output logic [POSITION_BITS-1:0] run_begin,
   output logic [POSITION_BITS-1:0] run_end,
   output srs_pkg::count_type       run_number
);
   import srs_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic                     active_ff, active_in;
   count_type                count_ff, count_in;
   count_type                runs_ff, runs_in;

   logic                     opposing, present, brk, emit_brk, emit_last;
   logic                     active_mid;
   count_type                count_mid, count_inc;
   logic [POSITION_BITS-1:0] pos_inc;

   always_comb begin
      opposing = ((hap_code == CODE_HOM_A) && (geno_code == CODE_HOM_B)) ||
                 ((hap_code == CODE_HOM_B) && (geno_code == CODE_HOM_A));
      present  = (hap_code != CODE_MISSING) && (geno_code != CODE_MISSING);
      brk      = opposing && active_ff;
      emit_brk = brk && (count_ff >= min_length);
      pos_inc   = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + POS_ONE;
      count_inc = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 1'b1;

      active_mid = active_ff;
      count_mid  = count_ff;
      start_in   = start_ff;
      if (brk) begin
         active_mid = 1'b0;
         count_mid  = '0;
      end else if (present) begin
         if (!active_ff) begin
            start_in = pos_inc;
         end
         active_mid = 1'b1;
         count_mid  = count_inc;
      end

      emit_last = region_last && active_mid && (count_mid >= min_length) && !emit_brk;
      emit      = emit_brk || emit_last;

      active_in = region_last ? 1'b0 : active_mid;
      count_in  = region_last ? '0 : count_mid;
      pos_in    = pos_inc;
      runs_in   = (emit && (runs_ff != COUNT_MAX)) ? runs_ff + 1'b1 : runs_ff;

      run_begin  = start_in;
      run_end    = pos_ff;
      run_number = runs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_ONE;
         start_ff  <= POS_ONE;
         active_ff <= 1'b0;
         count_ff  <= '0;
         runs_ff   <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         active_ff <= active_in;
         count_ff  <= count_in;
         runs_ff   <= runs_in;
      end
   end

endmodule

@@ hw/rtl/shared_run_segmenter_unit.sv @@
// Top level of the shared run segmenter: input beat register, run core and result register.
//
//  Channel   Direction  Beat contents
//  req_*     in         one locus: hap_code, geno_code, region_last on tlast
//  rsp_*     out        one emitted run: run_begin, run_end, run_number
//  csr_*     in         min_length write, no read-back
//
// One locus is taken every cycle while the result side does not stall; a result passes
// through the input beat register and then the result register before it is valid.
// Both the input beat register and the result register fill while the result side stalls,
// and the input side stalls only once both are held.
// Reset clears the valid flags and the run state, sets the position counter to 1; min_length returns to 1.
module shared_run_segmenter_unit #(
   parameter int POSITION_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // hap_code[1:0], geno_code[3:2], zeros above
   input  logic                   req_tlast,  // region_last
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [((2 * POSITION_BITS + srs_pkg::COUNT_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
                                              // run_begin, run_end, run_number, zeros above
   input  logic                   csr_wen,
   input  srs_pkg::count_type     csr_wdata
);
   import srs_pkg::*;

   localparam int PAYLOAD_BITS = 2 * POSITION_BITS + COUNT_BITS;
   localparam int RSP_BITS     = ((PAYLOAD_BITS + 7) / 8) * 8;
   localparam int PAD_BITS     = RSP_BITS - PAYLOAD_BITS;

   logic                     in_valid_ff, in_valid_in;
   code_type                 hap_ff, geno_ff;
   logic                     last_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [PAYLOAD_BITS-1:0]  out_data_ff;
   count_type                min_len_ff;
   logic                     advance, emit;
   logic [POSITION_BITS-1:0] run_begin, run_end;
   count_type                run_number;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_tready);

   srs_core #(
      .POSITION_BITS(POSITION_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .hap_code    (hap_ff),
      .geno_code   (geno_ff),
      .region_last (last_ff),
      .min_length  (min_len_ff),
      .emit        (emit),
      .run_begin   (run_begin),
      .run_end     (run_end),
      .run_number  (run_number)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         min_len_ff   <= MIN_LEN_INIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wen) begin
            min_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hap_ff  <= req_tdata[CODE_BITS-1:0];
         geno_ff <= req_tdata[2*CODE_BITS-1:CODE_BITS];
         last_ff <= req_tlast;
      end
      if (advance && emit) begin
         out_data_ff <= {run_number, run_end, run_begin};
      end
   end

   assign rsp_tvalid = out_valid_ff;

   generate
      if (PAD_BITS > 0) begin : g_pad
         assign rsp_tdata = {{PAD_BITS{1'b0}}, out_data_ff};
      end else begin : g_nopad
         assign rsp_tdata = out_data_ff;
      end
   endgenerate

endmodule
